FILE: rtl/core/rfrc_pkg.sv
`default_nettype none

package rfrc_pkg;

   // Opacity in Q1.15
   localparam int LEVEL_W = 16;
   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'd32768;

   // Configuration register indexes
   localparam logic [1:0] CSR_FADE_UP_MS   = 2'd0;
   localparam logic [1:0] CSR_FADE_DOWN_MS = 2'd1;
   localparam logic [1:0] CSR_CUT_DIST_SQ  = 2'd2;
   localparam logic [1:0] CSR_LOS_DISABLE  = 2'd3;

   // Configuration reset values
   localparam logic [23:0] FADE_UP_RESET   = 24'd5000;
   localparam logic [23:0] FADE_DOWN_RESET = 24'd1000;
   localparam logic [49:0] CUT_DIST_RESET  = 50'd589824;

   // Eye axis select for the shared squarer
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Number of quotient bits produced by the divider
   localparam int DIV_STEPS = 16;

   typedef enum logic [2:0] {
      MODE_IMMEDIATE   = 3'd0,
      MODE_UP          = 3'd1,
      MODE_DOWN        = 3'd2,
      MODE_FADING_UP   = 3'd3,
      MODE_FADING_DOWN = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SQ,
      ST_DIR,
      ST_REV_MUL,
      ST_REV_SUB,
      ST_ELAP,
      ST_DIV,
      ST_DIV_END,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       load;
      logic       clear_vis;
      logic       sq_mul;
      logic       sq_acc;
      logic [1:0] axis;
      logic       dir;
      logic       rev_mul;
      logic       rev_sub;
      logic       elap;
      logic       div_step;
      logic       div_end;
      logic       out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic invisible;
      logic los_dis;
      logic rev;
      logic need_div;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/reversible_fade_ramp_controller.sv
// A request passes the check, squarer, direction, elapsed-time, divider, divider-end and done
// states; a ramp reversal adds the reversal multiply and subtract states. With the
// line-of-sight checks disabled the 3-axis shared squarer is skipped; steady or completed
// ramps skip the 16-step restoring divider. A result held by the receiver stalls the next
// one. One request is taken at a time; with the checks enabled an invisible frame returns
// to idle with no result. Reset (synchronous, active high): immediate mode, opacity fully
// opaque, ramp start and stored eye cleared, registers back to their defaults.
`default_nettype none

module reversible_fade_ramp_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [31:0]        req_now_ms,
   input  wire logic               req_visible,
   input  wire logic               req_blocked,
   input  wire logic signed [23:0] req_eye_x,
   input  wire logic signed [23:0] req_eye_y,
   input  wire logic signed [23:0] req_eye_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [15:0]             rsp_opacity,
   output logic [2:0]              rsp_fade_mode,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [49:0]        csr_wdata
);
   import rfrc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   rfrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rfrc_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_now_ms    (req_now_ms),
      .req_visible   (req_visible),
      .req_blocked   (req_blocked),
      .req_eye_x     (req_eye_x),
      .req_eye_y     (req_eye_y),
      .req_eye_z     (req_eye_z),
      .rsp_opacity   (rsp_opacity),
      .rsp_fade_mode (rsp_fade_mode)
   );

   // One request at a time: no second beat right after one is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // Opacity never exceeds fully opaque
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_opacity <= FULL_LEVEL)
      else $error("opacity above full level");

   // Steady up means fully opaque, steady down means transparent
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fade_mode == MODE_UP) |-> rsp_opacity == FULL_LEVEL)
      else $error("steady up without full opacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fade_mode == MODE_DOWN) |-> rsp_opacity == '0)
      else $error("steady down with non-zero opacity");

endmodule

`default_nettype wire

FILE: rtl/core/rfrc_ctrl.sv
`default_nettype none

module rfrc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire rfrc_pkg::dp_status_type status,
   output rfrc_pkg::dp_cmd_type        cmd
);
   import rfrc_pkg::*;

   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(3);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // State, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            step_in = '0;
            if (status.invisible) begin
               cmd.clear_vis = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.los_dis) begin
               state_in = ST_DIR;
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            // Square one axis per beat, accumulate the previous square
            cmd.sq_mul = (step_ff != SQ_LAST);
            cmd.sq_acc = (step_ff != '0);
            cmd.axis   = step_ff[1:0];
            if (step_ff == SQ_LAST) begin
               step_in  = '0;
               state_in = ST_DIR;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIR: begin
            cmd.dir  = 1'b1;
            state_in = status.rev ? ST_REV_MUL : ST_ELAP;
         end
         ST_REV_MUL: begin
            cmd.rev_mul = 1'b1;
            state_in    = ST_REV_SUB;
         end
         ST_REV_SUB: begin
            cmd.rev_sub = 1'b1;
            state_in    = ST_ELAP;
         end
         ST_ELAP: begin
            cmd.elap = 1'b1;
            step_in  = '0;
            state_in = status.need_div ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               state_in = ST_DIV_END;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DIV_END: begin
            cmd.div_end = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rfrc_datapath.sv
`default_nettype none

module rfrc_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rfrc_pkg::dp_cmd_type   cmd,
   output rfrc_pkg::dp_status_type     status,
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [49:0]            csr_wdata,
   input  wire logic [31:0]            req_now_ms,
   input  wire logic                   req_visible,
   input  wire logic                   req_blocked,
   input  wire logic signed [23:0]     req_eye_x,
   input  wire logic signed [23:0]     req_eye_y,
   input  wire logic signed [23:0]     req_eye_z,
   output logic [15:0]                 rsp_opacity,
   output logic [2:0]                  rsp_fade_mode
);
   import rfrc_pkg::*;

   // Configuration
   logic [23:0] fade_up_ff, fade_up_in;
   logic [23:0] fade_down_ff, fade_down_in;
   logic [49:0] cut_ff, cut_in;
   logic        los_dis_ff, los_dis_in;

   // Latched request
   logic [31:0]        now_ff;
   logic               visible_ff, blocked_ff;
   logic signed [23:0] eye_x_ff, eye_y_ff, eye_z_ff;

   // Architectural state
   mode_type           mode_ff, mode_in;
   logic [31:0]        ramp_start_ff, ramp_start_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic signed [23:0] prev_x_ff, prev_x_in;
   logic signed [23:0] prev_y_ff, prev_y_in;
   logic signed [23:0] prev_z_ff, prev_z_in;

   // Working registers
   logic [47:0]        sq_ff, sq_in;
   logic [49:0]        acc_ff, acc_in;
   logic [39:0]        prod_ff, prod_in;
   logic [23:0]        rem_ff, rem_in;
   logic [15:0]        quo_ff, quo_in;
   logic [LEVEL_W-1:0] out_level_ff;
   logic [2:0]         out_mode_ff;

   // Combinational helpers
   logic [23:0]        dur_up, dur_down, d_sel;
   logic signed [23:0] cur_eye, prv_eye;
   logic signed [24:0] diff;
   logic signed [49:0] sq_full;
   logic               cut, hit, rev, sel_up, fading, over, ge;
   mode_type           m0;
   logic [15:0]        rev_opnd;
   logic [39:0]        rev_round;
   logic [31:0]        elapsed;
   logic [39:0]        num;
   logic [24:0]        trial, trial_sub;

   // A zero duration acts as one
   assign dur_up   = (fade_up_ff == '0) ? 24'd1 : fade_up_ff;
   assign dur_down = (fade_down_ff == '0) ? 24'd1 : fade_down_ff;

   assign sel_up = (mode_ff == MODE_FADING_UP);
   assign fading = sel_up || (mode_ff == MODE_FADING_DOWN);
   assign d_sel  = sel_up ? dur_up : dur_down;

   // Select one axis for the shared squarer
   always_comb begin
      case (cmd.axis)
         AXIS_X: begin
            cur_eye = eye_x_ff;
            prv_eye = prev_x_ff;
         end
         AXIS_Y: begin
            cur_eye = eye_y_ff;
            prv_eye = prev_y_ff;
         end
         default: begin
            cur_eye = eye_z_ff;
            prv_eye = prev_z_ff;
         end
      endcase
   end

   assign diff    = {cur_eye[23], cur_eye} - {prv_eye[23], prv_eye};
   assign sq_full = diff * diff;

   // Camera cut and direction
   assign cut = !los_dis_ff && (mode_ff != MODE_IMMEDIATE) && (acc_ff > cut_ff);
   assign m0  = cut ? MODE_IMMEDIATE : mode_ff;
   assign hit = !los_dis_ff && blocked_ff;
   assign rev = hit ? (m0 == MODE_FADING_UP) : (m0 == MODE_FADING_DOWN);

   // Reversal offset: round(operand * duration / 32768)
   assign rev_opnd  = sel_up ? level_ff : (FULL_LEVEL - level_ff);
   assign rev_round = prod_ff + 40'd16384;

   // Ramp position and divider set-up
   assign elapsed   = now_ff - ramp_start_ff;
   assign over      = elapsed > {8'd0, d_sel};
   assign num       = {1'b0, elapsed[23:0], 15'd0} + {17'd0, d_sel[23:1]};
   assign trial     = {rem_ff, quo_ff[15]};
   assign ge        = trial >= {1'b0, d_sel};
   assign trial_sub = trial - {1'b0, d_sel};

   always_comb begin
      fade_up_in    = fade_up_ff;
      fade_down_in  = fade_down_ff;
      cut_in        = cut_ff;
      los_dis_in    = los_dis_ff;
      mode_in       = mode_ff;
      ramp_start_in = ramp_start_ff;
      level_in      = level_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      prev_z_in     = prev_z_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;

      // Register writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_FADE_UP_MS:   fade_up_in   = csr_wdata[23:0];
            CSR_FADE_DOWN_MS: fade_down_in = csr_wdata[23:0];
            CSR_CUT_DIST_SQ:  cut_in       = csr_wdata;
            CSR_LOS_DISABLE:  los_dis_in   = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.load) begin
         acc_in = '0;
      end

      // Invisible target drops to immediate mode
      if (cmd.clear_vis) begin
         mode_in = MODE_IMMEDIATE;
      end

      if (cmd.sq_mul) begin
         sq_in = sq_full[47:0];
      end
      if (cmd.sq_acc) begin
         acc_in = acc_ff + {2'd0, sq_ff};
      end

      // Apply the fade direction
      if (cmd.dir) begin
         if (!los_dis_ff) begin
            prev_x_in = eye_x_ff;
            prev_y_in = eye_y_ff;
            prev_z_in = eye_z_ff;
         end
         mode_in = m0;
         if (hit) begin
            case (m0) inside
               MODE_FADING_UP: mode_in = MODE_FADING_DOWN;
               MODE_UP: begin
                  ramp_start_in = now_ff;
                  mode_in       = MODE_FADING_DOWN;
               end
               MODE_DOWN, MODE_FADING_DOWN: mode_in = m0;
               default: begin
                  level_in = '0;
                  mode_in  = MODE_DOWN;
               end
            endcase
         end else begin
            case (m0) inside
               MODE_FADING_DOWN: mode_in = MODE_FADING_UP;
               MODE_DOWN: begin
                  ramp_start_in = now_ff;
                  mode_in       = MODE_FADING_UP;
               end
               MODE_UP, MODE_FADING_UP: mode_in = m0;
               default: begin
                  level_in = FULL_LEVEL;
                  mode_in  = MODE_UP;
               end
            endcase
         end
      end

      // Shift the ramp start back so the ramp continues from the current level
      if (cmd.rev_mul) begin
         prod_in = {24'd0, rev_opnd} * {16'd0, d_sel};
      end
      if (cmd.rev_sub) begin
         ramp_start_in = now_ff - {7'd0, rev_round[39:15]};
      end

      // Finish the ramp or set up the divider
      if (cmd.elap && fading) begin
         if (over) begin
            level_in = sel_up ? FULL_LEVEL : '0;
            mode_in  = sel_up ? MODE_UP : MODE_DOWN;
         end else begin
            rem_in = num[39:16];
            quo_in = num[15:0];
         end
      end

      // One restoring division step
      if (cmd.div_step) begin
         rem_in = ge ? trial_sub[23:0] : trial[23:0];
         quo_in = {quo_ff[14:0], ge};
      end

      if (cmd.div_end) begin
         level_in = sel_up ? quo_ff : (FULL_LEVEL - quo_ff);
      end
   end

   // Configuration and state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         fade_up_ff    <= FADE_UP_RESET;
         fade_down_ff  <= FADE_DOWN_RESET;
         cut_ff        <= CUT_DIST_RESET;
         los_dis_ff    <= 1'b0;
         mode_ff       <= MODE_IMMEDIATE;
         ramp_start_ff <= '0;
         level_ff      <= FULL_LEVEL;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
      end else begin
         fade_up_ff    <= fade_up_in;
         fade_down_ff  <= fade_down_in;
         cut_ff        <= cut_in;
         los_dis_ff    <= los_dis_in;
         mode_ff       <= mode_in;
         ramp_start_ff <= ramp_start_in;
         level_ff      <= level_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         prev_z_ff     <= prev_z_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         now_ff     <= req_now_ms;
         visible_ff <= req_visible;
         blocked_ff <= req_blocked;
         eye_x_ff   <= req_eye_x;
         eye_y_ff   <= req_eye_y;
         eye_z_ff   <= req_eye_z;
      end
      if (cmd.out_load) begin
         out_level_ff <= level_ff;
         out_mode_ff  <= mode_ff;
      end
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign status.invisible = !los_dis_ff && !visible_ff;
   assign status.los_dis   = los_dis_ff;
   assign status.rev       = rev;
   assign status.need_div  = fading && !over;

   assign rsp_opacity   = out_level_ff;
   assign rsp_fade_mode = out_mode_ff;

endmodule

`default_nettype wire

FILE: verif/reversible_fade_ramp_controller_tb.sv
`timescale 1ns / 1ps

module reversible_fade_ramp_controller_tb;
   import rfrc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [31:0]        now;
      logic               visible;
      logic               blocked;
      logic signed [23:0] ex;
      logic signed [23:0] ey;
      logic signed [23:0] ez;
   } frame_beat_type;

   typedef struct packed {
      logic [15:0] opacity;
      mode_type    fmode;
   } fade_result_type;

   typedef struct {
      frame_beat_type  f;
      bit              typed;
      fade_result_type want;
   } guide_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [31:0]        req_now_ms;
   logic               req_visible;
   logic               req_blocked;
   logic signed [23:0] req_eye_x;
   logic signed [23:0] req_eye_y;
   logic signed [23:0] req_eye_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [15:0]        rsp_opacity;
   logic [2:0]         rsp_fade_mode;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [49:0]        csr_wdata;

   // Predictor copy of the registers
   logic [23:0] cfg_up_ms;
   logic [23:0] cfg_down_ms;
   logic [49:0] cfg_cut;
   logic        cfg_los_off;

   // Predictor copy of the fade state
   mode_type           ramp_mode;
   logic [31:0]        ramp_origin;
   logic [15:0]        op_level;
   logic signed [23:0] last_eye_x;
   logic signed [23:0] last_eye_y;
   logic signed [23:0] last_eye_z;

   // Random frame generator state
   logic [31:0]        gen_now;
   logic signed [23:0] gen_ex;
   logic signed [23:0] gen_ey;
   logic signed [23:0] gen_ez;
   logic               gen_blk;

   fade_result_type opacity_due[$];
   fade_result_type due_beat;
   guide_row_type   guide_rows[$];

   int  idle_pct;
   bit  hold_ask;
   int  hold_left;
   int  stall_left;
   int  cycle_count;
   int  frames_sent;
   int  silent_frames;
   int  checked_count;
   int  fault_count;
   int  setting_count;

   reversible_fade_ramp_controller u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_now_ms    (req_now_ms),
      .req_visible   (req_visible),
      .req_blocked   (req_blocked),
      .req_eye_x     (req_eye_x),
      .req_eye_y     (req_eye_y),
      .req_eye_z     (req_eye_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_opacity   (rsp_opacity),
      .rsp_fade_mode (rsp_fade_mode),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d results still due", cycle_count,
                  opacity_due.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // A duration of zero behaves as one millisecond
   function automatic logic [31:0] eff_dur(input logic [23:0] d);
      return (d == 24'd0) ? 32'd1 : {8'd0, d};
   endfunction

   // Advance the fade state by one frame; returns 1 when the frame yields a beat
   function automatic bit advance_fade(input frame_beat_type f, output fade_result_type r);
      longint      dx;
      longint      dy;
      longint      dz;
      logic [63:0] prod;
      logic [31:0] span;
      logic [31:0] elapsed;
      bit          hit;
      hit = 1'b0;
      r = '{opacity: 16'd0, fmode: MODE_IMMEDIATE};
      if (!cfg_los_off) begin
         // Invisible target drops to immediate with no beat
         if (!f.visible) begin
            ramp_mode = MODE_IMMEDIATE;
            return 1'b0;
         end
         // Treat a large viewer jump as a camera cut
         if (ramp_mode != MODE_IMMEDIATE) begin
            dx = longint'(f.ex) - longint'(last_eye_x);
            dy = longint'(f.ey) - longint'(last_eye_y);
            dz = longint'(f.ez) - longint'(last_eye_z);
            if (dx * dx + dy * dy + dz * dz > longint'({14'd0, cfg_cut}))
               ramp_mode = MODE_IMMEDIATE;
         end
         last_eye_x = f.ex;
         last_eye_y = f.ey;
         last_eye_z = f.ez;
         hit = f.blocked;
      end

      // Turn towards the requested direction
      if (hit) begin
         case (ramp_mode)
            MODE_FADING_UP: begin
               prod = {48'd0, FULL_LEVEL - op_level} * {32'd0, eff_dur(cfg_down_ms)}
                      + 64'd16384;
               ramp_origin = f.now - prod[46:15];
               ramp_mode = MODE_FADING_DOWN;
            end
            MODE_UP: begin
               ramp_origin = f.now;
               ramp_mode = MODE_FADING_DOWN;
            end
            MODE_DOWN, MODE_FADING_DOWN: ;
            default: begin
               op_level = 16'd0;
               ramp_mode = MODE_DOWN;
            end
         endcase
      end else begin
         case (ramp_mode)
            MODE_FADING_DOWN: begin
               prod = {48'd0, op_level} * {32'd0, eff_dur(cfg_up_ms)} + 64'd16384;
               ramp_origin = f.now - prod[46:15];
               ramp_mode = MODE_FADING_UP;
            end
            MODE_DOWN: begin
               ramp_origin = f.now;
               ramp_mode = MODE_FADING_UP;
            end
            MODE_UP, MODE_FADING_UP: ;
            default: begin
               op_level = FULL_LEVEL;
               ramp_mode = MODE_UP;
            end
         endcase
      end

      // Step the ramp, completing it once the duration has passed
      elapsed = f.now - ramp_origin;
      if (ramp_mode == MODE_FADING_UP) begin
         span = eff_dur(cfg_up_ms);
         if (elapsed > span) begin
            op_level = FULL_LEVEL;
            ramp_mode = MODE_UP;
         end else begin
            prod = ({32'd0, elapsed} * 64'd32768 + {33'd0, span[31:1]}) / {32'd0, span};
            op_level = prod[15:0];
         end
      end else if (ramp_mode == MODE_FADING_DOWN) begin
         span = eff_dur(cfg_down_ms);
         if (elapsed > span) begin
            op_level = 16'd0;
            ramp_mode = MODE_DOWN;
         end else begin
            prod = ({32'd0, elapsed} * 64'd32768 + {33'd0, span[31:1]}) / {32'd0, span};
            op_level = FULL_LEVEL - prod[15:0];
         end
      end
      r = '{opacity: op_level, fmode: ramp_mode};
      return 1'b1;
   endfunction

   // Offer one frame, hold it until accepted, then predict its beat
   task automatic send_frame(input frame_beat_type f, input bit typed,
                             input fade_result_type want);
      fade_result_type r;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_now_ms  <= f.now;
      req_visible <= f.visible;
      req_blocked <= f.blocked;
      req_eye_x   <= f.ex;
      req_eye_y   <= f.ey;
      req_eye_z   <= f.ez;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frames_sent++;
      if (advance_fade(f, r))
         opacity_due.push_back(typed ? want : r);
      else
         silent_frames++;
   endtask

   // Write one register; the caller drops valid after the last one
   task automatic write_csr(input logic [1:0] idx, input logic [49:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FADE_UP_MS:   cfg_up_ms = val[23:0];
         CSR_FADE_DOWN_MS: cfg_down_ms = val[23:0];
         CSR_CUT_DIST_SQ:  cfg_cut = val;
         CSR_LOS_DISABLE:  cfg_los_off = val[0];
         default: ;
      endcase
   endtask

   // Wait for every due beat, then let silent frames finish
   task automatic wait_drained();
      while (opacity_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_row(input logic [31:0] now, input logic vis, input logic blk,
                          input logic signed [23:0] ex, input logic signed [23:0] ey,
                          input logic signed [23:0] ez, input bit typed,
                          input logic [15:0] op, input mode_type md);
      guide_row_type g;
      g.f = '{now: now, visible: vis, blocked: blk, ex: ex, ey: ey, ez: ez};
      g.typed = typed;
      g.want = '{opacity: op, fmode: md};
      guide_rows.push_back(g);
   endtask

   // Random frames: time walks through ramps, eye mostly drifts, flags change now and then
   task automatic run_random(input int n);
      frame_beat_type f;
      logic [31:0]    span;
      int             pick;
      int             delta;
      repeat (n) begin
         span = eff_dur(cfg_up_ms) > eff_dur(cfg_down_ms) ? eff_dur(cfg_up_ms)
                                                          : eff_dur(cfg_down_ms);
         pick = $urandom_range(0, 99);
         if (pick < 70)
            gen_now = gen_now + $urandom_range(0, span / 3 + 1);
         else if (pick < 85)
            gen_now = gen_now + $urandom_range(0, span * 2);
         else if (pick < 95)
            gen_now = gen_now + $urandom_range(0, 3);
         else
            gen_now = $urandom;

         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            delta = int'($urandom_range(0, 512)) - 256;
            gen_ex = gen_ex + 24'(delta);
            delta = int'($urandom_range(0, 512)) - 256;
            gen_ey = gen_ey + 24'(delta);
            delta = int'($urandom_range(0, 512)) - 256;
            gen_ez = gen_ez + 24'(delta);
         end else if (pick < 90) begin
            delta = int'($urandom_range(0, 4096)) - 2048;
            gen_ex = gen_ex + 24'(delta);
            delta = int'($urandom_range(0, 4096)) - 2048;
            gen_ey = gen_ey + 24'(delta);
         end else begin
            gen_ex = 24'($urandom);
            gen_ey = 24'($urandom);
            gen_ez = 24'($urandom);
         end

         if ($urandom_range(0, 99) < 30)
            gen_blk = ~gen_blk;
         f = '{now: gen_now, visible: ($urandom_range(0, 9) != 0), blocked: gen_blk,
               ex: gen_ex, ey: gen_ey, ez: gen_ez};
         send_frame(f, 1'b0, '{opacity: 16'd0, fmode: MODE_IMMEDIATE});
      end
      req_valid <= 1'b0;
   endtask

   // One register setting: drain, write all four registers, then random frames
   task automatic run_phase(input logic [23:0] up, input logic [23:0] down,
                            input logic [49:0] cut, input logic los,
                            input int idle, input bit hold, input int n);
      wait_drained();
      write_csr(CSR_FADE_UP_MS, {26'd0, up});
      write_csr(CSR_FADE_DOWN_MS, {26'd0, down});
      write_csr(CSR_CUT_DIST_SQ, cut);
      write_csr(CSR_LOS_DISABLE, {49'd0, los});
      csr_valid <= 1'b0;
      setting_count++;
      idle_pct = idle;
      // Start the receiver hold only once frames are about to flow
      if (hold)
         hold_ask = 1'b1;
      run_random(n);
   endtask

   // Accept result beats, compare against the oldest due beat, idle at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (opacity_due.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_MAX)
                  $display("Stray beat: opacity %0d mode %0d", rsp_opacity, rsp_fade_mode);
            end else begin
               due_beat = opacity_due.pop_front();
               checked_count++;
               if (rsp_opacity !== due_beat.opacity || rsp_fade_mode !== due_beat.fmode) begin
                  fault_count++;
                  if (fault_count <= REPORT_MAX)
                     $display("Beat %0d: expected opacity %0d mode %0d, got opacity %0d mode %0d",
                              checked_count, due_beat.opacity, due_beat.fmode,
                              rsp_opacity, rsp_fade_mode);
               end
            end
         end
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_now_ms = '0;
      req_visible = 1'b0;
      req_blocked = 1'b0;
      req_eye_x = '0;
      req_eye_y = '0;
      req_eye_z = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_FADE_UP_MS;
      csr_wdata = '0;
      cfg_up_ms = FADE_UP_RESET;
      cfg_down_ms = FADE_DOWN_RESET;
      cfg_cut = CUT_DIST_RESET;
      cfg_los_off = 1'b0;
      ramp_mode = MODE_IMMEDIATE;
      ramp_origin = '0;
      op_level = FULL_LEVEL;
      last_eye_x = '0;
      last_eye_y = '0;
      last_eye_z = '0;
      gen_now = '0;
      gen_ex = '0;
      gen_ey = '0;
      gen_ez = '0;
      gen_blk = 1'b0;
      idle_pct = 20;
      hold_ask = 1'b0;
      hold_left = 0;
      stall_left = 0;
      cycle_count = 0;
      frames_sent = 0;
      silent_frames = 0;
      checked_count = 0;
      fault_count = 0;
      setting_count = 1;

      // Steady up, ramp down, reversal back up, ramp completion
      add_row(32'd0,    1, 0, 24'sd0, 24'sd0, 24'sd0, 1, FULL_LEVEL, MODE_UP);
      add_row(32'd100,  1, 1, 24'sd0, 24'sd0, 24'sd0, 1, FULL_LEVEL, MODE_FADING_DOWN);
      add_row(32'd600,  1, 1, 24'sd0, 24'sd0, 24'sd0, 1, 16'd16384, MODE_FADING_DOWN);
      add_row(32'd700,  1, 0, 24'sd0, 24'sd0, 24'sd0, 0, 16'd0, MODE_IMMEDIATE);
      add_row(32'd6000, 1, 0, 24'sd0, 24'sd0, 24'sd0, 0, 16'd0, MODE_IMMEDIATE);
      // Invisible target, then snap down from immediate
      add_row(32'd6100, 0, 0, 24'sd0, 24'sd0, 24'sd0, 0, 16'd0, MODE_IMMEDIATE);
      add_row(32'd6200, 1, 1, 24'sd0, 24'sd0, 24'sd0, 1, 16'd0, MODE_DOWN);
      // Jump exactly at the cut distance, then just beyond it
      add_row(32'd6300, 1, 1, 24'sd768, 24'sd0, 24'sd0, 1, 16'd0, MODE_DOWN);
      add_row(32'd6400, 1, 0, 24'sd1537, 24'sd0, 24'sd0, 1, FULL_LEVEL, MODE_UP);
      // Eye extremes force cuts
      add_row(32'd6500, 1, 1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1, 16'd0, MODE_DOWN);
      add_row(32'd6600, 1, 0, 24'sh800000, 24'sh800000, 24'sh800000, 1, FULL_LEVEL,
              MODE_UP);
      // Wrapped elapsed time completes the ramp
      add_row(32'd7000, 1, 1, 24'sh800000, 24'sh800000, 24'sh800000, 1, FULL_LEVEL,
              MODE_FADING_DOWN);
      add_row(32'd6999, 1, 1, 24'sh800000, 24'sh800000, 24'sh800000, 1, 16'd0, MODE_DOWN);
      add_row(32'hFFFF_FFFF, 1, 0, 24'sh800000, 24'sh800000, 24'sh800000, 1, 16'd0,
              MODE_FADING_UP);
      add_row(32'd0,    1, 0, 24'sh800000, 24'sh800000, 24'sh800000, 0, 16'd0,
              MODE_IMMEDIATE);
      add_row(32'd2499, 1, 1, 24'sh800000, 24'sh800000, 24'sh800000, 0, 16'd0,
              MODE_IMMEDIATE);
      // Invisible frame keeps the stored eye
      add_row(32'd2600, 0, 1, 24'sh123456, 24'sh654321, 24'sh2AAAAA, 0, 16'd0,
              MODE_IMMEDIATE);
      add_row(32'd2700, 1, 0, 24'sh800000, 24'sh800000, 24'sh800000, 1, FULL_LEVEL,
              MODE_UP);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames under the reset register values
      foreach (guide_rows[i])
         send_frame(guide_rows[i].f, guide_rows[i].typed, guide_rows[i].want);
      gen_now = 32'd2700;
      gen_ex = 24'sh800000;
      gen_ey = 24'sh800000;
      gen_ez = 24'sh800000;
      run_random(180);

      // Shortest ramps, every move a cut
      run_phase(24'd1, 24'd1, 50'd0, 1'b0, 25, 1'b0, 180);
      // Longest ramps, no cut ever; no idling here
      run_phase(24'hFFFFFF, 24'hFFFFFF, 50'h3_FFFF_FFFF_FFFF, 1'b0, 0, 1'b0, 180);
      // Zero durations with the checks switched off
      run_phase(24'd0, 24'd0, CUT_DIST_RESET, 1'b1, 20, 1'b0, 150);
      // Short ramps with a long receiver hold to back the block up
      run_phase(24'($urandom_range(1, 3000)), 24'($urandom_range(1, 3000)),
                CUT_DIST_RESET, 1'b0, 15, 1'b1, 250);
      run_phase(24'd40, 24'hFFFFFF, 50'($urandom_range(0, 2000000)), 1'b1, 30, 1'b0, 150);
      run_phase(24'($urandom_range(1, 20000)), 24'($urandom_range(1, 20000)),
                50'd1000000, 1'b0, 10, 1'b0, 250);
      // Final stretch at full rate
      run_phase(FADE_UP_RESET, FADE_DOWN_RESET, CUT_DIST_RESET, 1'b0, 0, 1'b0, 250);

      wait_drained();
      $display("Covered %0d frames over %0d register settings: %0d beats compared,",
               frames_sent, setting_count, checked_count);
      $display("%0d frames gave no beat, %0d faults seen", silent_frames, fault_count);
      if (fault_count == 0 && opacity_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
